FILE: sv/pfr_pkg.sv
`timescale 1ns / 1ps

package pfr_pkg;

    // Widths of the fixed-point words on the ports.
    localparam int DATA_W        = 32;
    localparam int LIMIT_W       = 31;
    localparam int FRAC_BITS_DEF = 16;

    // Shared multiplier: one bit of headroom over a data word on each operand.
    localparam int MUL_W  = DATA_W + 1;
    localparam int PROD_W = 2 * MUL_W;

    // Integral decay is a fixed Q0.16 factor, independent of the data format.
    localparam int DECAY_NUM   = 65529;
    localparam int DECAY_SHIFT = 16;

    // Small-error test: 400 * |error| < |target| means |error| < 0.0025 * |target|.
    localparam int SMALL_ERR_MUL = 400;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd4;

    typedef struct packed {
        logic signed [DATA_W-1:0] target_flow;
        logic signed [DATA_W-1:0] gain_p;
        logic signed [DATA_W-1:0] gain_i;
        logic signed [DATA_W-1:0] gain_d;
        logic [LIMIT_W-1:0]       integral_limit;
    } cfg_t;

    // Divider status as the sequencer sees it. The quotient is already
    // capped to 2^(DATA_W-1).
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quot;
    } div_res_t;

    // Magnitude of a signed data word; the most negative value maps to 2^(DATA_W-1).
    function automatic logic [DATA_W-1:0] mag_data(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
    endfunction

endpackage

FILE: sv/pfr_cfg.sv
`timescale 1ns / 1ps

module pfr_cfg
    import pfr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = aresetn;
    assign cfg     = cfg_reg;

    // Indexes past the last register are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_flow    <= '0;
            cfg_reg.gain_p         <= '0;
            cfg_reg.gain_i         <= '0;
            cfg_reg.gain_d         <= '0;
            cfg_reg.integral_limit <= '1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TARGET: cfg_reg.target_flow    <= cfg_data;
                REG_GAIN_P: cfg_reg.gain_p         <= cfg_data;
                REG_GAIN_I: cfg_reg.gain_i         <= cfg_data;
                REG_GAIN_D: cfg_reg.gain_d         <= cfg_data;
                REG_LIMIT:  cfg_reg.integral_limit <= cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: sv/pfr_mul.sv
`timescale 1ns / 1ps

module pfr_mul
    import pfr_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // The product is registered: it is ready in the cycle after the operands are presented.
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

FILE: sv/pfr_div.sv
`timescale 1ns / 1ps

module pfr_div
    import pfr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DATA_W:0]   dividend,
    input  logic [DATA_W-1:0] divisor,
    output div_res_t          res
);

    // The dividend is scaled by 2^FRAC_BITS so the quotient comes out in the
    // data format. One quotient bit is produced per cycle.
    localparam int NUM_W = DATA_W + 1 + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [DATA_W:0] QUOT_CAP = (DATA_W + 1)'(1) << (DATA_W - 1);

    logic [NUM_W-1:0]  num_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] div_reg;
    logic [DATA_W:0]   q_reg;
    logic              sticky_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DATA_W:0]   trial;
    logic              fits;
    logic [DATA_W:0]   diff;
    logic              cap;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg    <= {dividend, FRAC_BITS'(0)};
            div_reg    <= divisor;
            rem_reg    <= '0;
            q_reg      <= '0;
            sticky_reg <= 1'b0;
        end else if (busy_reg) begin
            num_reg    <= num_reg << 1;
            rem_reg    <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            q_reg      <= {q_reg[DATA_W-1:0], fits};
            sticky_reg <= sticky_reg | q_reg[DATA_W];
        end
    end

    // Any quotient above 2^(DATA_W-1) is pinned there.
    assign cap      = sticky_reg || (q_reg > QUOT_CAP);
    assign res.done = done_reg;
    assign res.quot = cap ? QUOT_CAP[DATA_W-1:0] : q_reg[DATA_W-1:0];

endmodule

FILE: sv/pid_flow_regulator_antiwindup.sv
`timescale 1ns / 1ps

// PID flow regulator with integral anti-windup. Each input beat is one control
// tick carrying a measured flow and the time step since the last tick, both
// fixed point with FRAC_BITS fraction bits. The block answers every tick with
// one output beat holding the saturated drive, the saturated error (target
// minus measurement) and the integral after its update and clamp. When the
// error is within 0.0025 of the target's magnitude the integral decays by
// 65529/65536 instead of accumulating; otherwise it gains error times the
// step, with the step capped at 0.01. The derivative is the change in error
// over the step, and a zero step counts as one LSB. The gain products and the
// error-times-step product round toward minus infinity; the decay truncates
// toward zero. Ticks are processed one at a time, and the input is ready again
// in the cycle after the result is loaded. The bit-serial derivative divider
// makes one quotient bit per cycle over FRAC_BITS + 33 bits (49 bits at Q16.16);
// the proportional and integral products are taken on the shared multiplier
// while it runs. A finished result waits in the output register, so the next
// tick can be taken and worked on while the previous output beat is still
// stalled. Configuration writes are taken at any time but must only be issued
// while no tick is in flight.

module pid_flow_regulator_antiwindup
    import pfr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Input beat: [31:0] measured_flow (signed), [63:32] time_step (unsigned).
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*DATA_W-1:0]   s_tdata,

    // Output beat: [31:0] drive_value, [63:32] flow_error, [95:64] integral_value.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [3*DATA_W-1:0]   m_tdata,

    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0]     cfg_data
);

    // The time step used for the integral is capped at round(0.01 * 2^FRAC_BITS).
    localparam logic [DATA_W-1:0] STEP_CAP = DATA_W'(((1 << FRAC_BITS) + 50) / 100);

    // A product shifted down by FRAC_BITS keeps PROD_W - FRAC_BITS meaningful bits.
    localparam int SUM_W = PROD_W - FRAC_BITS + 1;
    localparam int ACC_W = PROD_W - FRAC_BITS + 2;

    localparam logic signed [DATA_W-1:0] DMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DMIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Sequencer states.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ERR     = 4'd1;
    localparam logic [3:0] S_CMP     = 4'd2;
    localparam logic [3:0] S_BRANCH  = 4'd3;
    localparam logic [3:0] S_INTMUL  = 4'd4;
    localparam logic [3:0] S_INTUPD  = 4'd5;
    localparam logic [3:0] S_MULI    = 4'd6;
    localparam logic [3:0] S_ACCI    = 4'd7;
    localparam logic [3:0] S_WAITDIV = 4'd8;
    localparam logic [3:0] S_MULD    = 4'd9;
    localparam logic [3:0] S_SUM     = 4'd10;
    localparam logic [3:0] S_OUT     = 4'd11;

    cfg_t cfg;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Per-tick working registers.
    logic signed [DATA_W-1:0] meas_reg;
    logic [DATA_W-1:0]        dt_reg;
    logic signed [DATA_W-1:0] err_reg;
    logic                     decay_reg;
    logic                     diff_neg_reg;
    logic signed [DATA_W-1:0] deriv_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // Controller state kept across ticks.
    logic signed [DATA_W-1:0] integ_reg;
    logic signed [DATA_W-1:0] prev_err_reg;

    // Output register.
    logic                     m_valid_reg;
    logic [3*DATA_W-1:0]      m_data_reg;

    logic signed [MUL_W-1:0]  op_a;
    logic signed [MUL_W-1:0]  op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [ACC_W-1:0]  term;

    logic                     div_start;
    logic [DATA_W:0]          div_dividend;
    logic [DATA_W-1:0]        div_divisor;
    div_res_t                 div_res;

    logic signed [DATA_W:0]   err_wide;
    logic signed [DATA_W-1:0] err_sat;
    logic [DATA_W-1:0]        err_mag;
    logic [DATA_W-1:0]        target_mag;
    logic [DATA_W-1:0]        integ_mag;
    logic [DATA_W-1:0]        step;
    logic signed [DATA_W:0]   diff_wide;

    logic [DATA_W-1:0]        decay_mag;
    logic signed [SUM_W-1:0]  integ_cand;
    logic signed [SUM_W-1:0]  lim_pos;
    logic signed [SUM_W-1:0]  lim_neg;
    logic signed [DATA_W-1:0] integ_clamped;
    logic signed [DATA_W-1:0] deriv_val;
    logic signed [ACC_W-1:0]  drive_sum;
    logic signed [DATA_W-1:0] drive_sat;
    logic                     out_free;

    pfr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pfr_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    pfr_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .res      (div_res)
    );

    assign s_tready = aresetn && (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;

    // Error, saturated to the data width.
    assign err_wide = {cfg.target_flow[DATA_W-1], cfg.target_flow} -
                      {meas_reg[DATA_W-1], meas_reg};
    always_comb begin
        if (err_wide[DATA_W] != err_wide[DATA_W-1]) begin
            err_sat = err_wide[DATA_W] ? DMIN : DMAX;
        end else begin
            err_sat = err_wide[DATA_W-1:0];
        end
    end

    assign err_mag    = mag_data(err_reg);
    assign target_mag = mag_data(cfg.target_flow);
    assign integ_mag  = mag_data(integ_reg);
    assign step       = (dt_reg < STEP_CAP) ? dt_reg : STEP_CAP;

    // Derivative: |error - previous error| / step, the step floored at one LSB.
    assign diff_wide    = {err_reg[DATA_W-1], err_reg} - {prev_err_reg[DATA_W-1], prev_err_reg};
    assign div_dividend = diff_wide[DATA_W] ? (~diff_wide + (DATA_W + 1)'(1)) : diff_wide;
    assign div_divisor  = (dt_reg == '0) ? DATA_W'(1) : dt_reg;
    assign div_start    = (state_reg == S_CMP);

    // Shared multiplier operands, chosen by the sequencer.
    always_comb begin
        unique case (state_reg)
            S_CMP: begin
                op_a = {1'b0, err_mag};
                op_b = MUL_W'(SMALL_ERR_MUL);
            end
            S_INTMUL: begin
                if (decay_reg) begin
                    op_a = {1'b0, integ_mag};
                    op_b = MUL_W'(DECAY_NUM);
                end else begin
                    op_a = {err_reg[DATA_W-1], err_reg};
                    op_b = {1'b0, step};
                end
            end
            S_INTUPD: begin
                op_a = {cfg.gain_p[DATA_W-1], cfg.gain_p};
                op_b = {err_reg[DATA_W-1], err_reg};
            end
            S_MULI: begin
                op_a = {cfg.gain_i[DATA_W-1], cfg.gain_i};
                op_b = {integ_reg[DATA_W-1], integ_reg};
            end
            S_MULD: begin
                op_a = {cfg.gain_d[DATA_W-1], cfg.gain_d};
                op_b = {deriv_reg[DATA_W-1], deriv_reg};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Every gain product and the error-times-step product round toward minus infinity.
    assign prod_sh = prod >>> FRAC_BITS;
    assign term    = prod_sh[ACC_W-1:0];

    // Integral update. Decay works on the magnitude so it truncates toward zero.
    assign decay_mag = prod[DECAY_SHIFT +: DATA_W];
    always_comb begin
        if (decay_reg) begin
            if (integ_reg[DATA_W-1]) begin
                integ_cand = -$signed({{(SUM_W-DATA_W){1'b0}}, decay_mag});
            end else begin
                integ_cand = $signed({{(SUM_W-DATA_W){1'b0}}, decay_mag});
            end
        end else begin
            integ_cand = SUM_W'(integ_reg) + prod_sh[SUM_W-1:0];
        end
    end

    assign lim_pos = $signed({{(SUM_W-LIMIT_W){1'b0}}, cfg.integral_limit});
    assign lim_neg = -lim_pos;

    always_comb begin
        priority if (integ_cand > lim_pos) begin
            integ_clamped = lim_pos[DATA_W-1:0];
        end else if (integ_cand < lim_neg) begin
            integ_clamped = lim_neg[DATA_W-1:0];
        end else begin
            integ_clamped = integ_cand[DATA_W-1:0];
        end
    end

    // Signed derivative; a positive quotient of 2^(DATA_W-1) saturates.
    always_comb begin
        if (diff_neg_reg) begin
            deriv_val = ~div_res.quot + DATA_W'(1);
        end else if (div_res.quot[DATA_W-1]) begin
            deriv_val = DMAX;
        end else begin
            deriv_val = div_res.quot;
        end
    end

    assign drive_sum = acc_reg;
    always_comb begin
        priority if (drive_sum > ACC_W'(DMAX)) begin
            drive_sat = DMAX;
        end else if (drive_sum < ACC_W'(DMIN)) begin
            drive_sat = DMIN;
        end else begin
            drive_sat = drive_sum[DATA_W-1:0];
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (s_tvalid) state_next = S_ERR;
            S_ERR:     state_next = S_CMP;
            S_CMP:     state_next = S_BRANCH;
            S_BRANCH:  state_next = S_INTMUL;
            S_INTMUL:  state_next = S_INTUPD;
            S_INTUPD:  state_next = S_MULI;
            S_MULI:    state_next = S_ACCI;
            S_ACCI:    state_next = S_WAITDIV;
            S_WAITDIV: if (div_res.done) state_next = S_MULD;
            S_MULD:    state_next = S_SUM;
            S_SUM:     state_next = S_OUT;
            S_OUT:     if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            integ_reg    <= '0;
            prev_err_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_INTUPD) begin
                integ_reg <= integ_clamped;
            end
            if (state_reg == S_OUT && out_free) begin
                prev_err_reg <= err_reg;
                m_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers carry no reset; each is written before it is read.
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid && s_tready) begin
            meas_reg <= s_tdata[DATA_W-1:0];
            dt_reg   <= s_tdata[2*DATA_W-1:DATA_W];
        end
        if (state_reg == S_ERR) begin
            err_reg <= err_sat;
        end
        if (state_reg == S_CMP) begin
            diff_neg_reg <= diff_wide[DATA_W];
        end
        if (state_reg == S_BRANCH) begin
            decay_reg <= (err_mag == '0) || ($unsigned(prod) < PROD_W'(target_mag));
        end
        if (state_reg == S_MULI) begin
            acc_reg <= term;
        end
        if (state_reg == S_ACCI || state_reg == S_SUM) begin
            acc_reg <= acc_reg + term;
        end
        if (state_reg == S_WAITDIV && div_res.done) begin
            deriv_reg <= deriv_val;
        end
        if (state_reg == S_OUT && out_free) begin
            m_data_reg <= {integ_reg, err_reg, drive_sat};
        end
    end

endmodule

FILE: sv/pfr_checker.sv
`timescale 1ns / 1ps

module pfr_checker
    import pfr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [3*DATA_W-1:0]  m_tdata
);

    // A stalled output beat keeps its data.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // One tick at a time: the input closes right after a beat is taken.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still ready after an accepted beat");

    // A new result cannot appear in the cycle after a tick is taken.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid || $stable(m_tdata))
        else $error("result appeared too early after an input beat");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind pid_flow_regulator_antiwindup pfr_checker u_pfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
